[rtl/xfse_pkg.sv]
// Package for the XOR float stream encoder.
// Holds the shared widths, prefix codes and the chunk and window types.
// No dependencies.
package xfse_pkg;

    localparam int SAMPLE_W = 64;
    localparam int LEN_W    = 7;
    localparam int LEAD_W   = 5;
    localparam int TRAIL_W  = 6;

    localparam logic [1:0]        PFX_REUSE = 2'b01;
    localparam logic [1:0]        PFX_HDR   = 2'b11;
    localparam logic [LEAD_W-1:0] LEAD_MAX  = 5'd31;
    localparam logic [LEN_W-1:0]  HDR_LEN   = 7'd13;
    localparam logic [LEN_W-1:0]  PFX_LEN   = 7'd2;
    localparam logic [LEN_W-1:0]  FULL_LEN  = 7'd64;

    typedef struct packed {
        logic [SAMPLE_W-1:0] bits;
        logic [LEN_W-1:0]    len;
        logic                last;
    } chunk_t;

    typedef struct packed {
        logic [LEAD_W-1:0]  lead;
        logic [TRAIL_W-1:0] trail;
        logic [LEN_W-1:0]   width;
    } win_t;

    typedef struct packed {
        chunk_t c0;
        chunk_t c1;
        logic   two;
        win_t   win_next;
    } enc_res_t;

endpackage

[rtl/xfse_encode.sv]
// Combinational encoder for one sample: XOR, zero counts, window test, chunk build.
// Depends on xfse_pkg.
module xfse_encode import xfse_pkg::*; (
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                start,
    input  logic [SAMPLE_W-1:0] prev,
    input  win_t                win,
    output enc_res_t            res
);

    function automatic logic [LEN_W-1:0] tz_cnt(input logic [SAMPLE_W-1:0] v);
        logic [SAMPLE_W-1:0] oh;
        logic [LEN_W-1:0]    n;
        oh = v & (~v + 64'd1);
        n  = '0;
        for (int i = 0; i < SAMPLE_W; i++) begin
            n = n | (oh[i] ? LEN_W'(i) : '0);
        end
        return n;
    endfunction

    function automatic logic [SAMPLE_W-1:0] rev64(input logic [SAMPLE_W-1:0] v);
        logic [SAMPLE_W-1:0] r;
        for (int i = 0; i < SAMPLE_W; i++) begin
            r[i] = v[SAMPLE_W-1-i];
        end
        return r;
    endfunction

    logic [SAMPLE_W-1:0] x;
    logic [LEN_W-1:0]    lz;
    logic [LEN_W-1:0]    tz;
    logic                hit;
    logic [LEAD_W-1:0]   lzc;
    logic [LEN_W-1:0]    wnew;
    logic [TRAIL_W-1:0]  sh;
    logic [LEN_W-1:0]    wsel;
    logic [SAMPLE_W-1:0] data;
    logic [12:0]         hdr;

    always_comb begin
        x    = sample ^ prev;
        lz   = tz_cnt(rev64(x));
        tz   = tz_cnt(x);
        hit  = (win.width != '0) && ({2'b00, win.lead} <= lz)
               && ({1'b0, win.trail} <= tz);
        lzc  = (lz > {2'b00, LEAD_MAX}) ? LEAD_MAX : lz[LEAD_W-1:0];
        wnew = FULL_LEN - {2'b00, lzc} - tz;
        sh   = hit ? win.trail : tz[TRAIL_W-1:0];
        wsel = hit ? win.width : wnew;
        // bits above the meaningful field are already zero after the shift
        data = x >> sh;
        hdr  = {wnew[TRAIL_W-1:0], lzc, PFX_HDR};

        res.c0       = '{bits: '0, len: 7'd1, last: 1'b1};
        res.c1       = '{bits: data, len: wsel, last: 1'b1};
        res.two      = 1'b0;
        res.win_next = win;

        if (start) begin
            res.c0       = '{bits: sample, len: FULL_LEN, last: 1'b1};
            res.win_next = '0;
        end else if (x == '0) begin
            res.c0 = '{bits: '0, len: 7'd1, last: 1'b1};
        end else if (hit) begin
            if (wsel <= FULL_LEN - PFX_LEN) begin
                res.c0 = '{bits: {data[61:0], PFX_REUSE}, len: wsel + PFX_LEN, last: 1'b1};
            end else begin
                res.c0  = '{bits: {62'd0, PFX_REUSE}, len: PFX_LEN, last: 1'b0};
                res.two = 1'b1;
            end
        end else begin
            res.win_next = '{lead: lzc, trail: tz[TRAIL_W-1:0], width: wnew};
            if (wnew <= FULL_LEN - HDR_LEN) begin
                res.c0 = '{bits: {data[50:0], hdr}, len: wnew + HDR_LEN, last: 1'b1};
            end else begin
                res.c0  = '{bits: {51'd0, hdr}, len: HDR_LEN, last: 1'b0};
                res.two = 1'b1;
            end
        end
    end

endmodule

[rtl/xfse_out_buf.sv]
// Two-slot result buffer: output register plus a pending slot for split chunks.
// Depends on xfse_pkg.
module xfse_out_buf import xfse_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  chunk_t              c0,
    input  chunk_t              c1,
    input  logic                two,
    output logic                free,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [71:0]         m_tdata,  // chunk[63:0], chunk_len[70:64], zero pad[71]
    output logic                m_tlast
);

    logic   out_valid_reg, out_valid_next;
    logic   pend_valid_reg, pend_valid_next;
    chunk_t out_reg, out_next;
    chunk_t pend_reg, pend_next;

    assign free = !out_valid_reg || (m_tready && !pend_valid_reg);

    always_comb begin
        out_valid_next  = out_valid_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        pend_next       = pend_reg;
        if (m_tready && out_valid_reg) begin
            out_valid_next  = pend_valid_reg;
            out_next        = pend_reg;
            pend_valid_next = 1'b0;
        end
        if (load) begin
            out_valid_next  = 1'b1;
            out_next        = c0;
            pend_valid_next = two;
            pend_next       = c1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.len, out_reg.bits};
    assign m_tlast  = out_reg.last;

    a_pend_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> out_valid_reg)
        else $error("pending chunk without output chunk");

    a_first_has_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_reg.last) |-> pend_valid_reg)
        else $error("non-final chunk without its follow-up");

endmodule

[rtl/xor_float_stream_encoder.sv]
// XOR float stream encoder top level: input register, sample/window state, encoder, output buffer.
// Depends on xfse_pkg, xfse_encode, xfse_out_buf.
//
//  channel | dir | tdata                          | tuser        | tlast
//  s_      | in  | sample_bits[63:0]              | block_start  | -
//  m_      | out | chunk[63:0], chunk_len[70:64]  | -            | last_chunk
//
// One item is taken per cycle while the output buffer is free; an item that
// splits into two chunks holds the single output port for both chunks. Each
// item passes the input register and then the output register to the output.
// Reset clears the previous sample and the window. m_tready low stalls the
// output buffer, which then back-pressures the input register.
module xor_float_stream_encoder import xfse_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // sample_bits[63:0]
    input  logic        s_tuser,   // block_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // chunk[63:0], chunk_len[70:64], pad[71]
    output logic        m_tlast
);

    logic                in_valid_reg, in_valid_next;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic                in_start_reg;
    logic [SAMPLE_W-1:0] prev_reg;
    win_t                win_reg;
    enc_res_t            res;
    logic                free;
    logic                fire;
    logic                take;

    assign fire     = in_valid_reg && free;
    assign s_tready = !in_valid_reg || free;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            prev_reg     <= '0;
            win_reg      <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (fire) begin
                prev_reg <= in_sample_reg;
                win_reg  <= res.win_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_sample_reg <= s_tdata;
            in_start_reg  <= s_tuser;
        end
    end

    xfse_encode u_encode (
        .sample (in_sample_reg),
        .start  (in_start_reg),
        .prev   (prev_reg),
        .win    (win_reg),
        .res    (res)
    );

    xfse_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .c0       (res.c0),
        .c1       (res.c1),
        .two      (res.two),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_win_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (win_reg.width != '0) |->
        ({2'b00, win_reg.lead} + {1'b0, win_reg.trail} + win_reg.width == FULL_LEN))
        else $error("window bounds do not add up to 64");

    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_start_reg) |=> (win_reg == '0))
        else $error("block start did not clear the window");

endmodule
